// File: rtl/core/telemetry_line_parser_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the telemetry line parser modules.
// Both expect clk and rst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef TELEMETRY_LINE_PARSER_DEFINES_SVH
`define TELEMETRY_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define TLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlp_pkg
// Types, character codes and arithmetic constants of the telemetry line
// parser.
// ---------------------------------------------------------------------------
package tlp_pkg;

  // Field widths
  localparam int unsigned INT_W    = 16;  // integer part, saturating
  localparam int unsigned FRAC_W   = 20;  // fraction scaled to six digits
  localparam int unsigned SCALED_W = 30;  // fraction * 1024 + bias
  localparam int unsigned RECIP_W  = 31;
  localparam int unsigned PROD_W   = 61;
  localparam int unsigned QUOT_W   = 17;  // rounded binary fraction, up to 65536
  localparam int unsigned MAG_W    = 33;

  // floor(z / 15625) == (z * RECIP_MUL) >> RECIP_SHIFT for every z below 2^30
  localparam logic [RECIP_W-1:0]  RECIP_MUL   = 31'd1125899907;
  localparam int unsigned         RECIP_SHIFT = 44;
  // half of the 15625 divisor (10^6 / 128), rounds the scaled fraction half up
  localparam logic [SCALED_W-1:0] ROUND_BIAS  = 30'd7812;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_P     = 8'h70;

  // Targets of the accepted but unused names '5' and '6'
  localparam logic [3:0] TGT_NAME_5  = 4'd4;
  localparam logic [3:0] TGT_NAME_6  = 4'd5;

  // Targets with a name letter
  localparam logic [3:0] TGT_CURRENT = 4'd6;
  localparam logic [3:0] TGT_LOGIC_V = 4'd7;
  localparam logic [3:0] TGT_TEMP    = 4'd8;

  typedef enum logic [2:0] {
    ST_UPDATE      = 3'd0,
    ST_UNUSED      = 3'd1,
    ST_UNKNOWN     = 3'd2,
    ST_NO_COLON    = 3'd3,
    ST_MALFORMED   = 3'd4,
    ST_OVERRUN     = 3'd5,
    ST_NOT_NUMERIC = 3'd6
  } tlp_status_t;

  typedef enum logic [2:0] {
    PH_BLANK = 3'd0,  // skipping leading blanks
    PH_SIGN  = 3'd1,
    PH_INT   = 3'd2,
    PH_POINT = 3'd3,  // point with no digit before it
    PH_FRAC  = 3'd4,
    PH_DONE  = 3'd5,
    PH_BAD   = 3'd6
  } tlp_phase_t;

  // One line-end or overrun event on its way to value conversion
  typedef struct packed {
    tlp_status_t        status;
    logic [3:0]         target;
    logic               neg;
    logic               zero_val;
    logic [INT_W-1:0]   int_part;
    logic [FRAC_W-1:0]  frac;
  } tlp_record_t;

  // Weight of the fraction digit at a given position, six-digit scale
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [2:0] pos);
    logic [FRAC_W-1:0] w;
    case (pos)
      3'd0:    w = 20'd100000;
      3'd1:    w = 20'd10000;
      3'd2:    w = 20'd1000;
      3'd3:    w = 20'd100;
      3'd4:    w = 20'd10;
      3'd5:    w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tlp_line_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "telemetry_line_parser_defines.svh"
// ---------------------------------------------------------------------------
// tlp_line_tracker
// Running line state: length, the two characters before the first colon and
// the streaming number parser. At a line end or overrun it registers one
// event record.
// ---------------------------------------------------------------------------
module tlp_line_tracker #(
  parameter int unsigned LINE_CAPACITY   = 127,
  parameter int unsigned FRACTION_DIGITS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  logic [7:0]          rx_byte,
  output logic                rec_valid,
  input  logic                rec_ready,
  output tlp_pkg::tlp_record_t rec
);
  import tlp_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned CNT_W = $clog2(FRACTION_DIGITS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRACTION_DIGITS);

  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic              colon_r,  colon_nxt;
  logic [7:0]        older_r,  older_nxt;
  logic [7:0]        newer_r,  newer_nxt;
  tlp_phase_t        phase_r,  phase_nxt;
  logic              neg_r,    neg_nxt;
  logic [INT_W-1:0]  int_r,    int_nxt;
  logic [FRAC_W-1:0] frac_r,   frac_nxt;
  logic [CNT_W-1:0]  fcnt_r,   fcnt_nxt;
  logic              rec_valid_r, rec_valid_nxt;
  tlp_record_t       rec_r,    rec_nxt;

  logic              take_byte;
  logic              is_nul, is_eol, is_digit, is_blank, line_full;
  logic [3:0]        digit;
  logic [INT_W+3:0]  int_tmp;
  logic [INT_W-1:0]  int_sat;
  logic [FRAC_W-1:0] frac_add;
  tlp_phase_t        phase_num;
  logic              neg_num, add_int, add_frac;
  tlp_record_t       finish_rec, overrun_rec;

  assign byte_ready = !rec_valid_r || rec_ready;
  assign take_byte  = byte_valid && byte_ready;

  // Character classes
  assign is_nul    = (rx_byte == CH_NUL);
  assign is_eol    = rx_byte inside {CH_CR, CH_LF};
  assign is_digit  = rx_byte inside {[CH_0:CH_9]};
  assign is_blank  = rx_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
  assign digit     = rx_byte[3:0];
  assign line_full = (len_r >= LEN_MAX);

  // Digit accumulation: integer saturates, fraction kept on a six-digit scale
  assign int_tmp  = ({4'b0, int_r} << 3) + ({4'b0, int_r} << 1) + {16'b0, digit};
  assign int_sat  = (int_tmp > {4'b0, {INT_W{1'b1}}}) ? {INT_W{1'b1}} : int_tmp[INT_W-1:0];
  assign frac_add = frac_r + ({16'b0, digit} * frac_weight(3'(fcnt_r)));

  // Number parser next state for one tail character
  always_comb begin
    phase_num = phase_r;
    neg_num   = neg_r;
    add_int   = 1'b0;
    add_frac  = 1'b0;
    case (phase_r)
      PH_BLANK: begin
        if (!is_blank) begin
          if (rx_byte inside {CH_PLUS, CH_MINUS}) begin
            neg_num   = (rx_byte == CH_MINUS);
            phase_num = PH_SIGN;
          end else if (is_digit) begin
            add_int   = 1'b1;
            phase_num = PH_INT;
          end else if (rx_byte == CH_DOT) begin
            phase_num = PH_POINT;
          end else begin
            phase_num = PH_BAD;
          end
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          add_int   = 1'b1;
          phase_num = PH_INT;
        end else if (rx_byte == CH_DOT) begin
          phase_num = PH_POINT;
        end else begin
          phase_num = PH_BAD;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          add_int = 1'b1;
        end else if (rx_byte == CH_DOT) begin
          phase_num = PH_FRAC;
        end else begin
          phase_num = PH_DONE;
        end
      end
      PH_POINT: begin
        if (is_digit) begin
          add_frac  = 1'b1;
          phase_num = PH_FRAC;
        end else begin
          phase_num = PH_BAD;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          add_frac = 1'b1;
        end else begin
          phase_num = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Event records for a line end and for an overrun
  always_comb begin
    finish_rec          = '0;
    finish_rec.status   = ST_UPDATE;
    finish_rec.neg      = neg_r;
    finish_rec.int_part = int_r;
    finish_rec.frac     = frac_r;
    finish_rec.zero_val = (phase_r == PH_BLANK);
    if (!colon_r || (older_r == CH_NUL && newer_r == CH_NUL)) begin
      finish_rec.status = ST_NO_COLON;
    end else if (!(older_r inside {CH_M, CH_P})) begin
      finish_rec.status = ST_MALFORMED;
    end else if (phase_r inside {PH_SIGN, PH_POINT, PH_BAD}) begin
      finish_rec.status = ST_NOT_NUMERIC;
    end else if (newer_r inside {[CH_1:CH_4]}) begin
      finish_rec.target = 4'(newer_r - CH_1);
    end else if (newer_r inside {CH_5, CH_6}) begin
      finish_rec.target = 4'(newer_r - CH_1);
      finish_rec.status = ST_UNUSED;
    end else if (newer_r == CH_I) begin
      finish_rec.target = TGT_CURRENT;
    end else if (newer_r == CH_V) begin
      finish_rec.target = TGT_LOGIC_V;
    end else if (newer_r == CH_T) begin
      finish_rec.target = TGT_TEMP;
    end else begin
      finish_rec.status = ST_UNKNOWN;
    end
    if (finish_rec.status >= ST_UNKNOWN) begin
      finish_rec.target   = '0;
      finish_rec.zero_val = 1'b1;
    end

    overrun_rec          = '0;
    overrun_rec.status   = ST_OVERRUN;
    overrun_rec.zero_val = 1'b1;
  end

  // Line state next value
  always_comb begin
    len_nxt       = len_r;
    colon_nxt     = colon_r;
    older_nxt     = older_r;
    newer_nxt     = newer_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    int_nxt       = int_r;
    frac_nxt      = frac_r;
    fcnt_nxt      = fcnt_r;
    rec_valid_nxt = rec_valid_r;
    rec_nxt       = rec_r;
    if (byte_ready) begin
      rec_valid_nxt = 1'b0;
    end
    if (take_byte && !is_nul) begin
      if (line_full || is_eol) begin
        // Event and restart of the line
        rec_valid_nxt = 1'b1;
        rec_nxt       = line_full ? overrun_rec : finish_rec;
        len_nxt       = '0;
        colon_nxt     = 1'b0;
        older_nxt     = CH_NUL;
        newer_nxt     = CH_NUL;
        phase_nxt     = PH_BLANK;
        neg_nxt       = 1'b0;
        int_nxt       = '0;
        frac_nxt      = '0;
        fcnt_nxt      = '0;
      end else begin
        len_nxt = len_r + LEN_W'(1);
        if (!colon_r) begin
          if (rx_byte == CH_COLON) begin
            colon_nxt = 1'b1;
          end else begin
            older_nxt = newer_r;
            newer_nxt = rx_byte;
          end
        end else begin
          phase_nxt = phase_num;
          neg_nxt   = neg_num;
          if (add_int) begin
            int_nxt = int_sat;
          end
          if (add_frac && (fcnt_r < CNT_MAX)) begin
            frac_nxt = frac_add;
            fcnt_nxt = fcnt_r + CNT_W'(1);
          end
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      colon_r     <= 1'b0;
      older_r     <= CH_NUL;
      newer_r     <= CH_NUL;
      phase_r     <= PH_BLANK;
      neg_r       <= 1'b0;
      int_r       <= '0;
      frac_r      <= '0;
      fcnt_r      <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      colon_r     <= colon_nxt;
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      int_r       <= int_nxt;
      frac_r      <= frac_nxt;
      fcnt_r      <= fcnt_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
  end

  // Event payload
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  // Checks
  `TLP_ASSERT_NOW(a_len_bound, 1'b1, len_r <= LEN_MAX, "line length beyond capacity")
  `TLP_ASSERT_NOW(a_no_number_before_colon, !colon_r,
    (phase_r == PH_BLANK) && (int_r == '0) && (frac_r == '0), "number state before colon")
  `TLP_ASSERT_NEXT(a_eol_restarts, take_byte && is_eol,
    rec_valid_r && (len_r == '0) && !colon_r, "line end did not restart the line")

endmodule
`default_nettype wire

// File: rtl/core/tlp_value_conv.sv
`timescale 1ns / 1ps
`default_nettype none
`include "telemetry_line_parser_defines.svh"
// ---------------------------------------------------------------------------
// tlp_value_conv
// Turns an event record into the signed Q16.16 result: a reciprocal
// multiply rounds the decimal fraction, then the integer part is added,
// saturated and negated. Two registered stages, the last one is the output.
// ---------------------------------------------------------------------------
module tlp_value_conv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_valid,
  output logic                 rec_ready,
  input  tlp_pkg::tlp_record_t rec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [3:0]           out_target,
  output logic signed [31:0]   out_value
);
  import tlp_pkg::*;

  logic              s2_v_r, s2_v_nxt;
  tlp_status_t       s2_status_r;
  logic [3:0]        s2_target_r;
  logic              s2_neg_r, s2_zero_r;
  logic [INT_W-1:0]  s2_int_r;
  logic [QUOT_W-1:0] s2_quot_r;

  logic              out_v_r, out_v_nxt;
  tlp_status_t       out_status_r;
  logic [3:0]        out_target_r;
  logic [31:0]       out_value_r, value_nxt;

  logic              ready2, ready3;
  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  mag;
  logic [31:0]       mag_sat;

  // Stage handshake
  assign ready3    = !out_v_r || out_ready;
  assign ready2    = !s2_v_r || ready3;
  assign rec_ready = ready2;

  assign s2_v_nxt  = ready2 ? rec_valid : s2_v_r;
  assign out_v_nxt = ready3 ? s2_v_r : out_v_r;

  // Fraction rounding: floor((frac * 1024 + 7812) / 15625)
  assign scaled = {rec.frac, 10'b0} + ROUND_BIAS;
  assign prod   = PROD_W'(scaled) * PROD_W'(RECIP_MUL);

  // Magnitude, saturation and sign
  always_comb begin
    mag = {1'b0, s2_int_r, 16'b0} + MAG_W'(s2_quot_r);
    if (s2_neg_r) begin
      mag_sat   = (mag > 33'h080000000) ? 32'h80000000 : mag[31:0];
      value_nxt = 32'd0 - mag_sat;
    end else begin
      mag_sat   = (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
      value_nxt = mag_sat;
    end
    if (s2_zero_r) begin
      value_nxt = '0;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_status_r <= rec.status;
      s2_target_r <= rec.target;
      s2_neg_r    <= rec.neg;
      s2_zero_r   <= rec.zero_val;
      s2_int_r    <= rec.int_part;
      s2_quot_r   <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (ready3) begin
      out_status_r <= s2_status_r;
      out_target_r <= s2_target_r;
      out_value_r  <= value_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign out_status = out_status_r;
  assign out_target = out_target_r;
  assign out_value  = out_value_r;

  // Checks
  `TLP_ASSERT_NOW(a_quot_range, s2_v_r, s2_quot_r <= 17'd65536, "rounded fraction out of range")
  `TLP_ASSERT_NOW(a_reject_zeroed, out_v_r && (out_status_r >= ST_UNKNOWN),
    (out_value_r == '0) && (out_target_r == '0), "rejected line carries data")
  `TLP_ASSERT_NOW(a_unused_target, out_v_r && (out_status_r == ST_UNUSED),
    (out_target_r == TGT_NAME_5) || (out_target_r == TGT_NAME_6), "unused status with wrong target")

endmodule
`default_nettype wire

// File: rtl/core/telemetry_line_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Telemetry line parser: takes one received byte per cycle, sustained
// while the result port does not stall, and gives one status/target/value
// event per line end (CR or LF) or overrun. A new byte is accepted every
// clock while no stall backs up, line ends back to back included. An event
// passes the input register, line state, fraction multiply and output
// register in that order; the record and conversion registers hold events
// while the result port waits, and input stalls once they are all full.
// ---------------------------------------------------------------------------
// telemetry_line_parser
// Top level: input register, line tracker and value conversion.
// ---------------------------------------------------------------------------
module telemetry_line_parser #(
  parameter int unsigned LINE_CAPACITY   = 127,
  parameter int unsigned FRACTION_DIGITS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [3:0]         out_target,
  output logic signed [31:0] out_value
);
  import tlp_pkg::*;

  logic        in_v_r, in_v_nxt;
  logic [7:0]  in_byte_r;
  logic        byte_ready;
  logic        rec_valid, rec_ready;
  tlp_record_t rec;

  // Input register
  assign in_ready = !in_v_r || byte_ready;
  assign in_v_nxt = in_ready ? in_valid : in_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  tlp_line_tracker #(
    .LINE_CAPACITY   (LINE_CAPACITY),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_v_r),
    .byte_ready (byte_ready),
    .rx_byte    (in_byte_r),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec)
  );

  tlp_value_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_target (out_target),
    .out_value  (out_value)
  );

endmodule
`default_nettype wire
